[src/signed_piecewise_poly_command_top_assert.svh]
// ============================================================================
// Assertion macros for the piecewise polynomial command block
// Checks are compiled only when the design is not being synthesized.
// ============================================================================
`ifndef SIGNED_PIECEWISE_POLY_COMMAND_TOP_ASSERT_SVH
`define SIGNED_PIECEWISE_POLY_COMMAND_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("spc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("spc assertion failed");

`else

`define SPC_ASSERT_SAME(label, clk, rst, pre, post)
`define SPC_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

[src/spc_pkg.sv]
// ============================================================================
// spc_pkg
// Shared types and constants of the piecewise polynomial command block.
// ============================================================================
package spc_pkg;

   // Polynomial degree; powers above the register bank read as zero.
   localparam int DEGREE    = 4;
   localparam int NUM_PAIRS = 5;

   localparam int ADDR_W = 6;
   localparam int DATA_W = 64;
   localparam int IDX_LO = 3;
   localparam int IDX_W  = ADDR_W - IDX_LO;

   localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

   typedef logic [NUM_PAIRS-1:0][DATA_W-1:0] bank_type;

   // One item in flight between cells.
   typedef struct packed {
      logic               valid;
      logic               neg;
      logic               zero;
      logic signed [15:0] x;
      logic signed [47:0] acc;
   } stage_type;

   // An item after the multiply half of a cell.
   typedef struct packed {
      logic               valid;
      logic               neg;
      logic               zero;
      logic signed [15:0] x;
      logic signed [63:0] prod;
   } prod_type;

endpackage

[src/signed_piecewise_poly_command_top.sv]
// ============================================================================
// signed_piecewise_poly_command_top
// Speed to motor command through a pair of degree-4 polynomials.
// ============================================================================
// Usage:
//   Write the five coefficient pairs through the csr_ port (64-bit registers
//   at byte addresses 0, 8, 16, 24, 32; upper word for positive speed, lower
//   word for negative speed, Q16.16). Write them only while the block is idle.
//   Each req_ beat carries one signed speed sample and yields one rsp_ beat
//   with the rounded, saturated command and the clip flag; zero speed gives
//   zero. On its way to rsp_ a sample passes one entry register, two
//   registers in each of the four Horner cells (multiply, then round and
//   add) and the output register. One sample is taken every cycle while
//   req_stall is low. When the receiver stalls, the output register holds
//   its beat and the cells keep filling behind it; req_stall rises only
//   once every stage holds an item.
//   Reset empties the pipeline and clears all coefficients to zero.
// ============================================================================
module signed_piecewise_poly_command_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [15:0]            req_speed,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [15:0]            rsp_command,
   output logic                          rsp_clipped,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [spc_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [spc_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [spc_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   spc_pkg::bank_type   bank;
   logic signed [31:0]  coef_pos [spc_pkg::DEGREE+1];
   logic signed [31:0]  coef_neg [spc_pkg::DEGREE+1];
   spc_pkg::stage_type  chain [spc_pkg::DEGREE+1];
   logic                ready [spc_pkg::DEGREE+1];
   spc_pkg::stage_type  e_ff, e_in;
   logic                ready_e;

   spc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .bank        (bank)
   );

   // Coefficient of each power; the bank holds the highest power first.
   for (genvar p = 0; p <= spc_pkg::DEGREE; p++) begin : g_coef
      if (p < spc_pkg::NUM_PAIRS) begin : g_have
         assign coef_pos[p] = bank[spc_pkg::NUM_PAIRS-1-p][63:32];
         assign coef_neg[p] = bank[spc_pkg::NUM_PAIRS-1-p][31:0];
      end else begin : g_none
         assign coef_pos[p] = '0;
         assign coef_neg[p] = '0;
      end
   end

   // Entry register seeds the accumulator with the leading coefficient.
   assign ready_e   = !e_ff.valid || ready[0];
   assign req_stall = !ready_e;
   assign chain[0]  = e_ff;

   always_comb begin
      e_in = e_ff;
      if (ready_e) begin
         e_in.valid = req_valid;
         e_in.neg   = req_speed[15];
         e_in.zero  = req_speed == 16'sd0;
         e_in.x     = req_speed;
         e_in.acc   = req_speed[15] ? 48'(coef_neg[spc_pkg::DEGREE])
                                    : 48'(coef_pos[spc_pkg::DEGREE]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff.valid <= 1'b0;
      end else begin
         e_ff.valid <= e_in.valid;
      end
      e_ff.neg  <= e_in.neg;
      e_ff.zero <= e_in.zero;
      e_ff.x    <= e_in.x;
      e_ff.acc  <= e_in.acc;
   end

   for (genvar g = 0; g < spc_pkg::DEGREE; g++) begin : g_cell
      spc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up       (chain[g]),
         .up_ready (ready[g]),
         .coef_pos (coef_pos[spc_pkg::DEGREE-1-g]),
         .coef_neg (coef_neg[spc_pkg::DEGREE-1-g]),
         .dn       (chain[g+1]),
         .dn_ready (ready[g+1])
      );
   end

   spc_final u_final (
      .clock       (clock),
      .reset       (reset),
      .up          (chain[spc_pkg::DEGREE]),
      .up_ready    (ready[spc_pkg::DEGREE]),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_command (rsp_command),
      .rsp_clipped (rsp_clipped)
   );

endmodule

[src/spc_csr.sv]
// ============================================================================
// spc_csr
// Coefficient register bank behind the configuration port.
// ============================================================================
module spc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [spc_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [spc_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [spc_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready,
   output spc_pkg::bank_type             bank
);

   spc_pkg::bank_type             bank_ff;
   logic [spc_pkg::IDX_W-1:0]     idx;
   logic                          in_range;

   assign idx        = csr_paddr[spc_pkg::ADDR_W-1:spc_pkg::IDX_LO];
   assign in_range   = idx < spc_pkg::IDX_W'(spc_pkg::NUM_PAIRS);
   assign csr_pready = 1'b1;
   assign bank       = bank_ff;

   always_comb begin
      csr_prdata = '0;
      if (in_range) begin
         csr_prdata = bank_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && in_range) begin
         bank_ff[idx] <= csr_pwdata;
      end
   end

endmodule

[src/spc_cell.sv]
// ============================================================================
// spc_cell
// One Horner step: multiply by x, round, add the coefficient, saturate.
// ============================================================================
module spc_cell (
   input  logic                clock,
   input  logic                reset,
   input  spc_pkg::stage_type  up,
   output logic                up_ready,
   input  logic signed [31:0]  coef_pos,
   input  logic signed [31:0]  coef_neg,
   output spc_pkg::stage_type  dn,
   input  logic                dn_ready
);

   spc_pkg::prod_type   p_ff, p_in;
   spc_pkg::stage_type  a_ff, a_in;
   logic                ready_p, ready_a;
   logic signed [63:0]  rnd_sum;
   logic signed [48:0]  rounded;
   logic signed [31:0]  coef;
   logic signed [49:0]  sum;

   assign ready_a  = !a_ff.valid || dn_ready;
   assign ready_p  = !p_ff.valid || ready_a;
   assign up_ready = ready_p;
   assign dn       = a_ff;

   always_comb begin
      p_in       = p_ff;
      p_in.valid = ready_a ? 1'b0 : p_ff.valid;
      if (ready_p) begin
         p_in.valid = up.valid;
         p_in.neg   = up.neg;
         p_in.zero  = up.zero;
         p_in.x     = up.x;
         p_in.prod  = up.acc * up.x;
      end
   end

   // Adding one less on negative products turns the floor shift into
   // rounding half away from zero.
   assign rnd_sum = p_ff.prod + 64'sd16384 - $signed({63'd0, p_ff.prod[63]});
   assign rounded = rnd_sum[63:15];
   assign coef    = p_ff.neg ? coef_neg : coef_pos;
   assign sum     = {rounded[48], rounded} + {{18{coef[31]}}, coef};

   always_comb begin
      a_in = a_ff;
      if (ready_a) begin
         a_in.valid = p_ff.valid;
         a_in.neg   = p_ff.neg;
         a_in.zero  = p_ff.zero;
         a_in.x     = p_ff.x;
         if (sum[49:47] == 3'b000 || sum[49:47] == 3'b111) begin
            a_in.acc = sum[47:0];
         end else if (sum[49]) begin
            a_in.acc = spc_pkg::ACC_MIN;
         end else begin
            a_in.acc = spc_pkg::ACC_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff.valid <= 1'b0;
         a_ff.valid <= 1'b0;
      end else begin
         p_ff.valid <= p_in.valid;
         a_ff.valid <= a_in.valid;
      end
      p_ff.neg  <= p_in.neg;
      p_ff.zero <= p_in.zero;
      p_ff.x    <= p_in.x;
      p_ff.prod <= p_in.prod;
      a_ff.neg  <= a_in.neg;
      a_ff.zero <= a_in.zero;
      a_ff.x    <= a_in.x;
      a_ff.acc  <= a_in.acc;
   end

endmodule

[src/spc_final.sv]
// ============================================================================
// spc_final
// Rounds the accumulator to an integer command (zero for zero speed), saturates, holds the result.
// ============================================================================
`include "signed_piecewise_poly_command_top_assert.svh"

module spc_final (
   input  logic                clock,
   input  logic                reset,
   input  spc_pkg::stage_type  up,
   output logic                up_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_command,
   output logic                rsp_clipped
);

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]  rsp_command_ff, rsp_command_in;
   logic                rsp_clipped_ff, rsp_clipped_in;
   logic signed [48:0]  rnd_sum;
   logic signed [32:0]  r;

   assign up_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_command = rsp_command_ff;
   assign rsp_clipped = rsp_clipped_ff;

   assign rnd_sum = {up.acc[47], up.acc} + 49'sd32768 - $signed({48'd0, up.acc[47]});
   assign r       = rnd_sum[48:16];

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_command_in = rsp_command_ff;
      rsp_clipped_in = rsp_clipped_ff;
      if (up_ready) begin
         rsp_valid_in = up.valid;
         if (up.zero) begin
            rsp_command_in = '0;
            rsp_clipped_in = 1'b0;
         end else if (r[32:15] == '0 || r[32:15] == '1) begin
            rsp_command_in = r[15:0];
            rsp_clipped_in = 1'b0;
         end else begin
            rsp_command_in = r[32] ? 16'sh8000 : 16'sh7FFF;
            rsp_clipped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_command_ff <= rsp_command_in;
      rsp_clipped_ff <= rsp_clipped_in;
   end

   `SPC_ASSERT_NEXT(a_zero_speed, clock, reset, up.valid && up_ready && up.zero, rsp_command == 16'sd0 && !rsp_clipped)
   `SPC_ASSERT_SAME(a_clip_extreme, clock, reset, rsp_valid && rsp_clipped, rsp_command == 16'sh7FFF || rsp_command == 16'sh8000)
   `SPC_ASSERT_NEXT(a_sign_kept, clock, reset, up.valid && up_ready && !up.acc[47], !rsp_command[15])

endmodule
